### src/egcd_pkg.sv
package egcd_pkg;

    localparam int WIDTH_DEF = 64;   // operand width used by the datapath
    localparam int OPND_W    = 64;   // a, b
    localparam int G_W       = 63;   // g
    localparam int COEF_W    = 64;   // s, t and the internal coefficients
    localparam int PC_W      = 3;

    typedef struct packed {
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } t_in;

    typedef struct packed {
        logic        [G_W-1:0]    g;
        logic signed [COEF_W-1:0] s;
        logic signed [COEF_W-1:0] t;
    } t_out;

    // datapath operations driven by the microcode
    typedef enum logic [2:0] {
        OP_IDLE = 3'd0,
        OP_LOAD = 3'd1,
        OP_NORM = 3'd2,
        OP_LEAD = 3'd3,
        OP_SUB  = 3'd4,
        OP_FIN  = 3'd5
    } t_op;

    // sequencing condition of a microcode word
    typedef enum logic [1:0] {
        C_ALWAYS = 2'd0,
        C_IN     = 2'd1,
        C_OUT    = 2'd2,
        C_VZERO  = 2'd3
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] jmp;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctl;

endpackage

### src/egcd_seq.sv
module egcd_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  logic               i_v_zero,
    output egcd_pkg::t_ctl     o_ctl
);

    localparam logic [egcd_pkg::PC_W-1:0] PC_LOAD = egcd_pkg::PC_W'(0);
    localparam logic [egcd_pkg::PC_W-1:0] PC_NORM = egcd_pkg::PC_W'(1);
    localparam logic [egcd_pkg::PC_W-1:0] PC_LEAD = egcd_pkg::PC_W'(2);
    localparam logic [egcd_pkg::PC_W-1:0] PC_SUB  = egcd_pkg::PC_W'(3);
    localparam logic [egcd_pkg::PC_W-1:0] PC_FIX  = egcd_pkg::PC_W'(4);
    localparam logic [egcd_pkg::PC_W-1:0] PC_FIN  = egcd_pkg::PC_W'(5);

    // control store: taken condition goes to jmp, otherwise to pc + 1
    function automatic egcd_pkg::t_uword ucode(input logic [egcd_pkg::PC_W-1:0] pc);
        egcd_pkg::t_uword w;
        case (pc)
            PC_LOAD: w = '{egcd_pkg::OP_LOAD, egcd_pkg::C_IN,     PC_NORM};
            PC_NORM: w = '{egcd_pkg::OP_NORM, egcd_pkg::C_ALWAYS, PC_LEAD};
            PC_LEAD: w = '{egcd_pkg::OP_LEAD, egcd_pkg::C_VZERO,  PC_FIN};
            PC_SUB:  w = '{egcd_pkg::OP_SUB,  egcd_pkg::C_ALWAYS, PC_FIX};
            PC_FIX:  w = '{egcd_pkg::OP_NORM, egcd_pkg::C_ALWAYS, PC_LEAD};
            PC_FIN:  w = '{egcd_pkg::OP_FIN,  egcd_pkg::C_OUT,    PC_LOAD};
            default: w = '{egcd_pkg::OP_IDLE, egcd_pkg::C_ALWAYS, PC_LOAD};
        endcase
        return w;
    endfunction

    logic [egcd_pkg::PC_W-1:0] r_pc;
    logic [egcd_pkg::PC_W-1:0] n_pc;
    logic                      r_out_valid;
    logic                      n_out_valid;
    egcd_pkg::t_uword          word;
    logic                      stall;
    logic                      taken;

    always_comb begin
        word  = ucode(r_pc);
        stall = ((word.cond == egcd_pkg::C_IN) && !i_in_valid) ||
                ((word.cond == egcd_pkg::C_OUT) && r_out_valid && !i_out_ready);
        taken = (word.cond == egcd_pkg::C_VZERO) ? i_v_zero : 1'b1;
        if (stall) begin
            n_pc = r_pc;
        end else if (taken) begin
            n_pc = word.jmp;
        end else begin
            n_pc = r_pc + egcd_pkg::PC_W'(1);
        end
        if (!stall && (word.op == egcd_pkg::OP_FIN)) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // no word is taken while reset is held
    assign o_in_ready  = i_rst_n && (word.op == egcd_pkg::OP_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_ctl.op    = word.op;
    assign o_ctl.fire  = !stall;

endmodule

### src/egcd_dp.sv
module egcd_dp #(
    parameter int WIDTH = egcd_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  egcd_pkg::t_ctl   i_ctl,
    input  egcd_pkg::t_in    i_data,
    output egcd_pkg::t_out   o_data,
    output logic             o_v_zero
);

    localparam int LW = $clog2(WIDTH);
    localparam int CW = egcd_pkg::COEF_W;

    // saturated magnitude of a WIDTH-bit two's complement value
    function automatic logic [WIDTH-2:0] mag_of(input logic [WIDTH-1:0] x);
        logic [WIDTH-1:0] m;
        m = x[WIDTH-1] ? (~x + 1'b1) : x;
        return m[WIDTH-1] ? '1 : m[WIDTH-2:0];
    endfunction

    function automatic logic [LW-1:0] lead_of(input logic [WIDTH-1:0] x);
        logic [LW-1:0] pos;
        pos = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (x[i]) begin
                pos = LW'(i);
            end
        end
        return pos;
    endfunction

    logic [CW-1:0]    r_u1, r_u2, r_v1, r_v2;
    logic [WIDTH-1:0] r_u3, r_v3;
    logic [LW-1:0]    r_k;
    logic             r_a_neg, r_b_neg;
    logic [WIDTH-2:0] r_a_mag, r_b_mag;
    egcd_pkg::t_out   r_out;

    logic [WIDTH-1:0] a_raw, b_raw;
    logic [CW-1:0]    u1n, u2n;
    logic [WIDTH-1:0] u3n;
    logic             swap;
    logic             eq_a, eq_b;
    egcd_pkg::t_out   n_out;

    always_comb begin
        a_raw = i_data.a[WIDTH-1:0];
        b_raw = i_data.b[WIDTH-1:0];

        // a negative remainder flips the whole triple
        u3n  = r_u3[WIDTH-1] ? (~r_u3 + 1'b1) : r_u3;
        u1n  = r_u3[WIDTH-1] ? (~r_u1 + 1'b1) : r_u1;
        u2n  = r_u3[WIDTH-1] ? (~r_u2 + 1'b1) : r_u2;
        swap = (u3n < r_v3);

        eq_a = (r_u3 == {1'b0, r_a_mag});
        eq_b = (r_u3 == {1'b0, r_b_mag});
        n_out.g = egcd_pkg::G_W'(r_u3[WIDTH-2:0]);
        if (eq_a) begin
            n_out.s = r_a_neg ? '1 : CW'(1);
            n_out.t = '0;
        end else if (eq_b) begin
            n_out.s = '0;
            n_out.t = r_b_neg ? '1 : CW'(1);
        end else begin
            n_out.s = r_a_neg ? (~r_u1 + 1'b1) : r_u1;
            n_out.t = r_b_neg ? (~r_u2 + 1'b1) : r_u2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            case (i_ctl.op)
                egcd_pkg::OP_LOAD: begin
                    r_a_neg <= a_raw[WIDTH-1];
                    r_b_neg <= b_raw[WIDTH-1];
                    r_a_mag <= mag_of(a_raw);
                    r_b_mag <= mag_of(b_raw);
                    r_u1    <= CW'(1);
                    r_u2    <= '0;
                    r_u3    <= {1'b0, mag_of(a_raw)};
                    r_v1    <= '0;
                    r_v2    <= CW'(1);
                    r_v3    <= {1'b0, mag_of(b_raw)};
                end
                egcd_pkg::OP_NORM: begin
                    if (swap) begin
                        r_u1 <= r_v1;
                        r_u2 <= r_v2;
                        r_u3 <= r_v3;
                        r_v1 <= u1n;
                        r_v2 <= u2n;
                        r_v3 <= u3n;
                    end else begin
                        r_u1 <= u1n;
                        r_u2 <= u2n;
                        r_u3 <= u3n;
                    end
                end
                egcd_pkg::OP_LEAD: begin
                    // u3 >= v3 here, so the difference never wraps
                    r_k <= lead_of(r_u3) - lead_of(r_v3);
                end
                egcd_pkg::OP_SUB: begin
                    r_u1 <= r_u1 - (r_v1 << r_k);
                    r_u2 <= r_u2 - (r_v2 << r_k);
                    r_u3 <= r_u3 - (r_v3 << r_k);
                end
                egcd_pkg::OP_FIN: begin
                    r_out <= n_out;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_data   = r_out;
    assign o_v_zero = (r_v3 == '0);

endmodule

### src/extended_gcd_left_to_right_top.sv
// Extended gcd of two signed words: returns g = gcd(|a|,|b|) with Bezout coefficients s and t,
// g = s*a + t*b, using left-to-right binary reduction; only the low WIDTH bits of a and b are
// used and the most negative value is saturated by one. If g equals |a| the result is
// s = sign(a), t = 0; else if g equals |b| it is s = 0, t = sign(b); both zero gives g = 0,
// s = 1, t = 0. Coefficients wrap in 64 bits and are not reduced. One word is worked at a
// time by a six-word microcode program driving one shift-subtract datapath: each reduction
// round has three steps (leading-one compare, shifted subtract, sign fix and swap), repeated
// until the v remainder is zero. A finished result sits in an output register, and the next
// word is taken while it waits.
module extended_gcd_left_to_right_top #(
    parameter int WIDTH = egcd_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  egcd_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output egcd_pkg::t_out   o_out_data
);

    egcd_pkg::t_ctl ctl;
    logic           v_zero;

    egcd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_v_zero    (v_zero),
        .o_ctl       (ctl)
    );

    egcd_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_data   (i_in_data),
        .o_data   (o_out_data),
        .o_v_zero (v_zero)
    );

    // a result never overwrites one that is still waiting
    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.fire && (ctl.op == egcd_pkg::OP_FIN)) |-> (!o_out_valid || i_out_ready))
        else $error("result written over a waiting word");

    // a shifted subtract only runs with a nonzero divisor remainder
    a_sub_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.fire && (ctl.op == egcd_pkg::OP_SUB)) |-> !v_zero)
        else $error("subtract step with zero v remainder");

    // one word in flight: no new word right after one is taken
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice in a row");

endmodule
